[rtl/core/life_pkg.sv]
// Shared types, field widths and helper functions of the life automaton block.
package life_pkg;

   localparam int COMMAND_WIDTH  = 2;
   localparam int COLUMN_WIDTH   = 5;
   localparam int ROW_WIDTH      = 5;
   localparam int CFG_WIDTH      = 6;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CFG_WIDTH-1:0] CFG_SIZE_RESET = 6'd32;

   localparam logic [3:0] SURVIVE_COUNT = 4'd2;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;

   localparam int SEL_COUNT = 3;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_STEP  = 2'd2
   } command_type;

   typedef enum logic {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SWEEP,
      ST_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      ROLE_CUR,
      ROLE_NEXT,
      ROLE_PREV
   } role_type;

   function automatic logic [1:0] next_sel(input logic [1:0] sel);
      logic [1:0] res;
      res = (sel == 2'(SEL_COUNT - 1)) ? 2'd0 : sel + 2'd1;
      return res;
   endfunction

   function automatic role_type role_of(input logic [1:0] mem, input logic [1:0] cur);
      role_type res;
      if (mem == cur) begin
         res = ROLE_CUR;
      end else if (mem == next_sel(cur)) begin
         res = ROLE_NEXT;
      end else begin
         res = ROLE_PREV;
      end
      return res;
   endfunction

endpackage

[rtl/core/life_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module life_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/life_automaton_generation_step.sv]
// Top level of the life automaton: bounded board, cell access and generation step.
// The board lives in three row-wide RAMs that take turns as the current, previous and
// scratch boards, so a committed step only renames them. After reset a clearing pass
// zeroes every row of the RAMs and no command beat is taken meanwhile. A read, write or
// unused command moves to the access state, which raises its result beat once the output
// is free and returns to idle in the same cycle. In a step, one row of the current board
// is read per cycle and the next row is computed from a three-row window, written to the
// scratch board and compared against the current and previous rows; the settle decision
// is then made in the decide state. A result beat that is not taken holds back the next
// result, in the access or decide state, until it is taken. Size registers may be written
// at any time but take effect for whole commands only when written while the block is
// idle.
module life_automaton_generation_step #(
   parameter int MAX_COLUMNS = 32,
   parameter int MAX_ROWS    = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // column [4:0], row [9:5], cell_in [10], zero [15:11]
   input  logic [life_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // command [1:0]
   input  logic [life_pkg::COMMAND_WIDTH-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // cell_out [0], settled [1], zero [7:2]
   output logic [life_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_index,
   input  logic [life_pkg::CFG_WIDTH-1:0]        csr_data
);

   import life_pkg::*;

   localparam int RW   = $clog2(MAX_ROWS);
   localparam int CNTW = $clog2(MAX_ROWS + 2);
   localparam logic [CNTW-1:0] CNT_LAST_CLEAR = CNTW'(MAX_ROWS - 1);
   localparam logic [CNTW-1:0] CNT_LAST_SWEEP = CNTW'(MAX_ROWS + 1);

   state_type                  state_ff, state_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;
   logic [1:0]                 cur_sel_ff, cur_sel_in;
   logic [CFG_WIDTH-1:0]       cols_cfg_ff, cols_cfg_in;
   logic [CFG_WIDTH-1:0]       rows_cfg_ff, rows_cfg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_cell_ff, rsp_cell_in;
   logic                       rsp_settled_ff, rsp_settled_in;
   logic [COMMAND_WIDTH-1:0]   cmd_ff, cmd_in;
   logic [COLUMN_WIDTH-1:0]    col_ff, col_in;
   logic [ROW_WIDTH-1:0]       row_ff, row_in;
   logic                       cell_ff, cell_in;
   logic [MAX_COLUMNS-1:0]     above_ff, above_in;
   logic [MAX_COLUMNS-1:0]     mid_ff, mid_in;
   logic                       diff_prev_ff, diff_prev_in;
   logic                       diff_cur_ff, diff_cur_in;

   logic                       ram_we    [SEL_COUNT];
   logic [RW-1:0]              ram_waddr [SEL_COUNT];
   logic [MAX_COLUMNS-1:0]     ram_wdata [SEL_COUNT];
   logic [RW-1:0]              ram_raddr [SEL_COUNT];
   logic [MAX_COLUMNS-1:0]     ram_rdata [SEL_COUNT];

   logic                       out_free;
   logic [MAX_COLUMNS-1:0]     col_mask;
   logic [MAX_COLUMNS-1:0]     cur_rd, prev_rd;
   logic [MAX_COLUMNS-1:0]     below_row, new_row;
   logic                       below_in_area, y_in_area, y_valid;
   logic                       addr_in_area;
   logic [MAX_COLUMNS-1:0]     bit_mask, cell_wdata;
   logic                       cur_we, next_we, clear_we;
   logic [RW-1:0]              cur_raddr, prev_raddr, cur_waddr, next_waddr;
   logic [MAX_COLUMNS-1:0]     next_wdata;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 2){1'b0}}, rsp_settled_ff, rsp_cell_ff};

   always_comb begin
      for (int x = 0; x < MAX_COLUMNS; x++) begin
         col_mask[x] = x < int'(cols_cfg_ff);
      end
   end

   always_comb begin
      cur_rd  = '0;
      prev_rd = '0;
      for (int i = 0; i < SEL_COUNT; i++) begin
         if (role_of(2'(i), cur_sel_ff) == ROLE_CUR) begin
            cur_rd = ram_rdata[i];
         end
         if (role_of(2'(i), cur_sel_ff) == ROLE_PREV) begin
            prev_rd = ram_rdata[i];
         end
      end
   end

   // Sweep window: the RAM returns row cnt-1 while row cnt-2 is computed.
   always_comb begin
      logic [MAX_COLUMNS+1:0] a_pad, m_pad, b_pad;
      logic [3:0]             n;
      below_in_area = (int'(cnt_ff) >= 1) && (int'(cnt_ff) - 1 < int'(rows_cfg_ff))
                      && (int'(cnt_ff) - 1 < MAX_ROWS);
      y_valid       = int'(cnt_ff) >= 2;
      y_in_area     = y_valid && (int'(cnt_ff) - 2 < int'(rows_cfg_ff));
      below_row     = below_in_area ? (cur_rd & col_mask) : '0;
      a_pad = {1'b0, above_ff, 1'b0};
      m_pad = {1'b0, mid_ff, 1'b0};
      b_pad = {1'b0, below_row, 1'b0};
      for (int x = 0; x < MAX_COLUMNS; x++) begin
         n = 4'(a_pad[x]) + 4'(a_pad[x+1]) + 4'(a_pad[x+2])
           + 4'(m_pad[x]) + 4'(m_pad[x+2])
           + 4'(b_pad[x]) + 4'(b_pad[x+1]) + 4'(b_pad[x+2]);
         new_row[x] = col_mask[x] & (mid_ff[x] ? (n == SURVIVE_COUNT || n == BIRTH_COUNT)
                                               : (n == BIRTH_COUNT));
      end
   end

   assign addr_in_area = ({1'b0, col_ff} < cols_cfg_ff) && (int'(col_ff) < MAX_COLUMNS)
                      && ({1'b0, row_ff} < rows_cfg_ff) && (int'(row_ff) < MAX_ROWS);
   assign bit_mask   = {{(MAX_COLUMNS - 1){1'b0}}, 1'b1} << col_ff;
   assign cell_wdata = cell_ff ? (cur_rd | bit_mask) : (cur_rd & ~bit_mask);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cur_sel_in     = cur_sel_ff;
      cols_cfg_in    = cols_cfg_ff;
      rows_cfg_in    = rows_cfg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_cell_in    = rsp_cell_ff;
      rsp_settled_in = rsp_settled_ff;
      cmd_in         = cmd_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      cell_in        = cell_ff;
      above_in       = above_ff;
      mid_in         = mid_ff;
      diff_prev_in   = diff_prev_ff;
      diff_cur_in    = diff_cur_ff;
      clear_we       = 1'b0;
      cur_we         = 1'b0;
      next_we        = 1'b0;
      cur_raddr      = '0;
      prev_raddr     = '0;
      cur_waddr      = RW'(row_ff);
      next_waddr     = '0;
      next_wdata     = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMNS: cols_cfg_in = csr_data;
            CSR_ROWS:    rows_cfg_in = csr_data;
            default:     cols_cfg_in = cols_cfg_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clear_we = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST_CLEAR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cur_raddr = RW'(req_tdata[COLUMN_WIDTH +: ROW_WIDTH]);
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               col_in  = req_tdata[0 +: COLUMN_WIDTH];
               row_in  = req_tdata[COLUMN_WIDTH +: ROW_WIDTH];
               cell_in = req_tdata[COLUMN_WIDTH + ROW_WIDTH];
               if (req_tuser == CMD_STEP) begin
                  state_in     = ST_SWEEP;
                  cnt_in       = '0;
                  above_in     = '0;
                  mid_in       = '0;
                  diff_prev_in = 1'b0;
                  diff_cur_in  = 1'b0;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            cur_raddr = RW'(row_ff);
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = (cmd_ff == CMD_READ) && addr_in_area
                                && cur_rd[0 +: MAX_COLUMNS] != '0
                                && ((cur_rd >> col_ff) & {{(MAX_COLUMNS - 1){1'b0}}, 1'b1}) != '0;
               rsp_settled_in = 1'b0;
               cur_we         = (cmd_ff == CMD_WRITE) && addr_in_area;
               state_in       = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (int'(cnt_ff) < MAX_ROWS) begin
               cur_raddr = RW'(cnt_ff);
            end
            if (cnt_ff != '0) begin
               prev_raddr = RW'(cnt_ff - 1'b1);
               above_in   = mid_ff;
               mid_in     = below_row;
            end
            if (y_valid) begin
               next_we    = 1'b1;
               next_waddr = RW'(cnt_ff - 2'd2);
               next_wdata = y_in_area ? new_row : '0;
               if (y_in_area) begin
                  diff_prev_in = diff_prev_ff || (((new_row ^ prev_rd) & col_mask) != '0);
                  diff_cur_in  = diff_cur_ff || (((new_row ^ mid_ff) & col_mask) != '0);
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST_SWEEP) begin
               cnt_in   = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_cell_in    = 1'b0;
               rsp_settled_in = !diff_prev_ff || !diff_cur_ff;
               if (diff_prev_ff && diff_cur_ff) begin
                  cur_sel_in = next_sel(cur_sel_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < SEL_COUNT; i++) begin
         ram_we[i]    = clear_we;
         ram_waddr[i] = RW'(cnt_ff);
         ram_wdata[i] = '0;
         ram_raddr[i] = '0;
         case (role_of(2'(i), cur_sel_ff))
            ROLE_CUR: begin
               ram_raddr[i] = cur_raddr;
               if (cur_we) begin
                  ram_we[i]    = 1'b1;
                  ram_waddr[i] = cur_waddr;
                  ram_wdata[i] = cell_wdata;
               end
            end
            ROLE_NEXT: begin
               if (next_we) begin
                  ram_we[i]    = 1'b1;
                  ram_waddr[i] = next_waddr;
                  ram_wdata[i] = next_wdata;
               end
            end
            ROLE_PREV: begin
               ram_raddr[i] = prev_raddr;
            end
            default: begin
               ram_raddr[i] = '0;
            end
         endcase
      end
   end

   for (genvar g = 0; g < SEL_COUNT; g++) begin : g_board
      life_ram #(
         .WIDTH (MAX_COLUMNS),
         .DEPTH (MAX_ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[g]),
         .wr_addr (ram_waddr[g]),
         .wr_data (ram_wdata[g]),
         .rd_addr (ram_raddr[g]),
         .rd_data (ram_rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         cur_sel_ff   <= '0;
         cols_cfg_ff  <= CFG_SIZE_RESET;
         rows_cfg_ff  <= CFG_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_sel_ff   <= cur_sel_in;
         cols_cfg_ff  <= cols_cfg_in;
         rows_cfg_ff  <= rows_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff    <= rsp_cell_in;
      rsp_settled_ff <= rsp_settled_in;
      cmd_ff         <= cmd_in;
      col_ff         <= col_in;
      row_ff         <= row_in;
      cell_ff        <= cell_in;
      above_ff       <= above_in;
      mid_ff         <= mid_in;
      diff_prev_ff   <= diff_prev_in;
      diff_cur_ff    <= diff_cur_in;
   end

`ifndef SYNTH
   a_rotate_on_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && out_free && diff_prev_ff && diff_cur_ff)
      |=> cur_sel_ff != $past(cur_sel_ff))
      else $error("Board roles did not rotate on a committed step.");

   a_settled_no_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_settled_ff) |-> !rsp_cell_ff)
      else $error("Settled beat carries a cell value.");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_sel_ff) < SEL_COUNT)
      else $error("Board role selector out of range.");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> cnt_ff <= CNT_LAST_SWEEP)
      else $error("Sweep counter ran past the last row.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready))
      |-> ($past(state_ff) == ST_ACCESS || $past(state_ff) == ST_DECIDE))
      else $error("Result beat appeared outside a finishing state.");
`endif

endmodule
